// ===== rtl/sha256_byte_stream_hash_assert.svh =====
// Assertion macros for the SHA-256 byte stream hash.
// Used by the top level only; no other dependencies.
`ifndef SHA256_BYTE_STREAM_HASH_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASH_ASSERT_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SHA_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SHA_ASSERT_IMPL(label, clk, rst, prop, msg)
`define SHA_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== rtl/sha_pkg.sv =====
// Shared types, constants and functions for the SHA-256 byte stream hash.
// No dependencies.
`default_nettype none
package sha_pkg;
   localparam int unsigned QueueDepth = 2;

   typedef struct packed {
      logic [7:0] msg_byte;
      logic       byte_present;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [63:0] digest_w0;
      logic [63:0] digest_w1;
      logic [63:0] digest_w2;
      logic [63:0] digest_w3;
   } rsp_type;

   // Classified command handed from front to back.
   typedef struct packed {
      logic [7:0] data;
      logic       has_data;
      logic       finish;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_OUT
   } back_state_type;

   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [5:0] LenPos  = 6'd56;

   localparam logic [255:0] InitHash = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] k;
      unique case (t)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
         6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
         6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
         6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
      return (v >> n) | (v << (32 - n));
   endfunction
endpackage
`default_nettype wire

// ===== rtl/sha_front.sv =====
// Front end: takes request transfers, drops empty non-last items and
// queues the rest for the back end. Depends on sha_pkg.
`default_nettype none
module sha_front #(
   parameter int unsigned QDEPTH = sha_pkg::QueueDepth
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire sha_pkg::req_type req_data,
   output logic                  cmd_valid,
   input  wire logic             cmd_take,
   output sha_pkg::cmd_type      cmd_data
);
   import sha_pkg::*;
   localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

   cmd_type          q_ff [QDEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;
   logic             push, keep;

   assign req_stall = (count_ff == PW'(0) + (PW+1)'(QDEPTH));
   assign keep      = req_data.byte_present | req_data.last_byte;
   assign push      = req_valid & ~req_stall & keep;
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_take) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + (PW+1)'(push) - (PW+1)'(cmd_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= '{data: req_data.msg_byte, has_data: req_data.byte_present,
                              finish: req_data.last_byte};
      end
   end
endmodule
`default_nettype wire

// ===== rtl/sha_back.sv =====
// Back end: block store, length counter, padding sequencer and a
// one-round-per-cycle compression core. Depends on sha_pkg.
`default_nettype none
module sha_back (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         cmd_valid,
   output logic              cmd_take,
   input  wire sha_pkg::cmd_type cmd_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output sha_pkg::rsp_type  rsp_data,
   output logic              busy
);
   import sha_pkg::*;

   back_state_type state_ff, state_in;
   // Block store kept as 16 big-endian words; each byte lands in its lane.
   logic [31:0]  blk_ff [16];
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  len_ff, len_in, msg_len_ff, msg_len_in;
   logic [255:0] chain_ff, chain_in;
   logic [31:0]  wv_ff [8];
   logic [31:0]  wv_in [8];
   logic [31:0]  win_ff [16];
   logic [31:0]  w_cur;
   logic [5:0]   t_ff, t_in;
   logic         pend_fin_ff, pend_fin_in;   // finish after current compression
   logic         padding_ff, padding_in;     // inside pad sequence
   logic         pad_first_ff, pad_first_in;
   logic         wr_en, load_wv, do_round, last_blk_ff, last_blk_in;
   logic [7:0]   wr_byte;
   rsp_type      out_ff, out_in;
   logic [31:0]  s0, s1, ch, mj, t1, t2, ws0, ws1, w15, w2;

   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = out_ff;
   assign busy      = (state_ff != ST_IDLE);

   // Schedule word for the current round.
   always_comb begin
      w15 = win_ff[4'(t_ff - 6'd15)];
      w2  = win_ff[4'(t_ff - 6'd2)];
      ws0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
      ws1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
      if (t_ff < 6'd16) begin
         w_cur = blk_ff[t_ff[3:0]];
      end else begin
         w_cur = win_ff[t_ff[3:0]] + ws0 + win_ff[4'(t_ff - 6'd7)] + ws1;
      end
      s1 = rotr(wv_ff[4], 6) ^ rotr(wv_ff[4], 11) ^ rotr(wv_ff[4], 25);
      ch = (wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6]);
      t1 = wv_ff[7] + s1 + ch + round_k(t_ff) + w_cur;
      s0 = rotr(wv_ff[0], 2) ^ rotr(wv_ff[0], 13) ^ rotr(wv_ff[0], 22);
      mj = (wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]);
      t2 = s0 + mj;
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      len_in       = len_ff;
      msg_len_in   = msg_len_ff;
      chain_in     = chain_ff;
      t_in         = t_ff;
      pend_fin_in  = pend_fin_ff;
      padding_in   = padding_ff;
      pad_first_in = pad_first_ff;
      last_blk_in  = last_blk_ff;
      out_in       = out_ff;
      cmd_take     = 1'b0;
      wr_en        = 1'b0;
      wr_byte      = cmd_data.data;
      load_wv      = 1'b0;
      do_round     = 1'b0;
      for (int i = 0; i < 8; i++) wv_in[i] = wv_ff[i];
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               if (cmd_data.has_data) begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + 6'd1;
                  len_in  = len_ff + 64'd8;
               end
               pend_fin_in = cmd_data.finish;
               msg_len_in  = cmd_data.has_data ? len_ff + 64'd8 : len_ff;
               if (cmd_data.has_data && fill_ff == 6'd63) begin
                  state_in = ST_ROUND;
                  load_wv  = 1'b1;
                  t_in     = '0;
               end else if (cmd_data.finish) begin
                  state_in     = ST_PAD;
                  pad_first_in = 1'b1;
               end
            end
         end
         ST_PAD: begin
            // Write one pad byte per cycle.
            wr_en        = 1'b1;
            pad_first_in = 1'b0;
            fill_in      = fill_ff + 6'd1;
            if (pad_first_ff) begin
               wr_byte = PadByte;
            end else if (fill_ff >= LenPos && last_blk_ff) begin
               wr_byte = msg_len_ff[8'(8'd63 - {fill_ff[2:0], 3'd0}) -: 8];
            end else begin
               wr_byte = 8'h00;
            end
            padding_in = 1'b1;
            if (fill_ff == 6'd63) begin
               state_in = ST_ROUND;
               load_wv  = 1'b1;
               t_in     = '0;
            end
         end
         ST_ROUND: begin
            do_round = 1'b1;
            wv_in[7] = wv_ff[6];
            wv_in[6] = wv_ff[5];
            wv_in[5] = wv_ff[4];
            wv_in[4] = wv_ff[3] + t1;
            wv_in[3] = wv_ff[2];
            wv_in[2] = wv_ff[1];
            wv_in[1] = wv_ff[0];
            wv_in[0] = t1 + t2;
            t_in     = t_ff + 6'd1;
            if (t_ff == 6'd63) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[255 - 32*i -: 32] = chain_ff[255 - 32*i -: 32] + wv_ff[i];
            end
            if (padding_ff && last_blk_ff) begin
               out_in       = chain_in;
               state_in     = ST_OUT;
               padding_in   = 1'b0;
               pend_fin_in  = 1'b0;
               last_blk_in  = 1'b0;
            end else if (pend_fin_ff) begin
               state_in     = ST_PAD;
               pad_first_in = ~padding_ff;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
               chain_in = InitHash;
               len_in   = '0;
               fill_in  = '0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // Length goes into this block only if the pad byte fits before byte 56.
      if (state_ff == ST_PAD && pad_first_ff) last_blk_in = (fill_ff < LenPos);
      if (state_ff == ST_PAD && !pad_first_ff && fill_ff == 6'd0) last_blk_in = 1'b1;
      if (state_ff == ST_IDLE && cmd_valid && cmd_data.has_data && fill_ff == 6'd63 &&
          cmd_data.finish) begin
         last_blk_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         len_ff       <= '0;
         chain_ff     <= InitHash;
         pend_fin_ff  <= 1'b0;
         padding_ff   <= 1'b0;
         pad_first_ff <= 1'b0;
         last_blk_ff  <= 1'b0;
         t_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         len_ff       <= len_in;
         chain_ff     <= chain_in;
         pend_fin_ff  <= pend_fin_in;
         padding_ff   <= padding_in;
         pad_first_ff <= pad_first_in;
         last_blk_ff  <= last_blk_in;
         t_ff         <= t_in;
      end
   end

   always_ff @(posedge clock) begin
      msg_len_ff <= msg_len_in;
      out_ff     <= out_in;
      if (wr_en) blk_ff[fill_ff[5:2]][(5'd24 - {fill_ff[1:0], 3'd0}) +: 8] <= wr_byte;
      if (load_wv) begin
         for (int i = 0; i < 8; i++) wv_ff[i] <= chain_ff[255 - 32*i -: 32];
      end else if (do_round) begin
         for (int i = 0; i < 8; i++) wv_ff[i] <= wv_in[i];
      end
      if (do_round) win_ff[t_ff[3:0]] <= w_cur;
   end
endmodule
`default_nettype wire

// ===== rtl/sha256_byte_stream_hash.sv =====
// SHA-256 byte stream hash, top level: front queue plus back compression engine.
// Depends on sha_pkg, sha_front, sha_back and the assertion macro header.
//
// One byte is absorbed per transfer; a byte that completes a 64-byte block
// starts a compression of 64 rounds at one round per cycle in the single
// round unit, then a fold step adds the result into the chain value. A last
// transfer adds one pad byte per cycle up to the block end and one or two
// compressions, then the digest is held on rsp_ until taken. A small queue
// in front keeps taking requests while the engine is busy, until it fills;
// empty non-last items are dropped there. The chain value returns to the
// initial hash once the digest is taken.
`default_nettype none
module sha256_byte_stream_hash #(
   parameter int unsigned QDEPTH = sha_pkg::QueueDepth
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire sha_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output sha_pkg::rsp_type      rsp_data
);
   import sha_pkg::*;
`include "sha256_byte_stream_hash_assert.svh"

   logic    cmd_valid, cmd_take, busy;
   cmd_type cmd_data;

   sha_front #(.QDEPTH(QDEPTH)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .cmd_valid, .cmd_take, .cmd_data
   );

   sha_back u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd_data,
      .rsp_valid, .rsp_stall, .rsp_data, .busy
   );

   // The engine only pulls from the queue when something is there.
   `SHA_ASSERT_NEVER(a_take_empty, clock, reset, cmd_take && !cmd_valid, "take from empty queue")
   // A digest waiting means the engine is busy.
   `SHA_ASSERT_NEVER(a_rsp_busy, clock, reset, rsp_valid && !busy, "digest while idle")
   // A stalled digest holds.
   `SHA_ASSERT_IMPL(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "digest dropped")
endmodule
`default_nettype wire
